[rtl/vdts_pkg.sv]
// Shared types and constants for the viscous differential torque split.
// Used by the pipeline modules and the top level; depends on nothing.
`default_nettype none
package vdts_pkg;

	// Points of the (2/pi)*atan table over [0, 1], plus the end point.
	localparam int ATAN_ENTRIES = 1024;
	localparam int ATAN_AW = (ATAN_ENTRIES > 1) ? $clog2(ATAN_ENTRIES) : 1;

	// Reciprocal 2^56 / |x| for |x| above one: 28 quotient bits, two per stage.
	localparam int DIV_BITS = 28;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_PER_STAGE;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_AXLE_RATIO        = 3'd0;
	localparam cfg_idx_t REG_DRIVE_EFFICIENCY  = 3'd1;
	localparam cfg_idx_t REG_VISCOUS_COEFF     = 3'd2;
	localparam cfg_idx_t REG_COULOMB_TORQUE    = 3'd3;
	localparam cfg_idx_t REG_COULOMB_STIFFNESS = 3'd4;
	localparam cfg_idx_t REG_LOCK_GAIN         = 3'd5;
	localparam cfg_idx_t REG_LOCK_LIMIT        = 3'd6;

	typedef struct packed {
		logic [23:0] axle_ratio;
		logic [16:0] drive_efficiency;
		logic [23:0] viscous_coeff;
		logic [31:0] coulomb_torque;
		logic [23:0] coulomb_stiffness;
		logic [23:0] lock_gain;
		logic [30:0] lock_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] motor_torque;
		logic signed [23:0] rear_left_speed;
		logic signed [23:0] rear_right_speed;
	} item_t;

	// Front end result: torque terms plus the magnitude of the atan argument.
	typedef struct packed {
		logic signed [31:0] tq;
		logic signed [44:0] visc;
		logic signed [31:0] lock;
		logic [55:0] mag;
		logic neg;
		logic near;
	} front_t;

	// Torque terms plus the smooth sign, signed Q1.16.
	typedef struct packed {
		logic signed [31:0] tq;
		logic signed [44:0] visc;
		logic signed [31:0] lock;
		logic signed [17:0] sgn;
	} tail_t;

endpackage
`default_nettype wire

[rtl/vdts_in_if.sv]
// Input request channel: motor torque and rear wheel speeds.
// Stand-alone interface, no dependencies.
`default_nettype none
interface vdts_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] motor_torque;
	logic signed [23:0] rear_left_speed;
	logic signed [23:0] rear_right_speed;

	modport source(output valid, motor_torque, rear_left_speed, rear_right_speed,
		input ready);
	modport sink(input valid, motor_torque, rear_left_speed, rear_right_speed,
		output ready);
endinterface
`default_nettype wire

[rtl/vdts_out_if.sv]
// Result channel: rear left and right wheel torques.
// Stand-alone interface, no dependencies.
`default_nettype none
interface vdts_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] rear_left_torque;
	logic signed [31:0] rear_right_torque;

	modport source(output valid, rear_left_torque, rear_right_torque, input ready);
	modport sink(input valid, rear_left_torque, rear_right_torque, output ready);
endinterface
`default_nettype wire

[rtl/vdts_cfg_if.sv]
// Configuration write channel: register index and write data.
// Stand-alone interface, no dependencies.
`default_nettype none
interface vdts_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] reg_index;
	logic [31:0] wdata;

	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

[rtl/vdts_front.sv]
// Front end: motor speed, viscous drag, atan argument and clamped locking torque.
// Five register stages; depends on vdts_pkg.
`default_nettype none
module vdts_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  vdts_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  vdts_pkg::item_t item,
	output logic            out_valid,
	output vdts_pkg::front_t front
);
	import vdts_pkg::*;

	logic [4:0] v_s;

	logic signed [24:0] l_x, r_x, abs_l, abs_r;
	logic [25:0] abs_sum;
	logic [12:0] fade;

	logic signed [31:0] tq_s1, tq_s2, tq_s3, tq_s4;
	logic signed [24:0] sum_s1, diff_s1;
	logic [12:0] fade_s1;

	logic signed [49:0] sg_s2;
	logic signed [38:0] pdf_s2;

	logic signed [31:0] w_s3;
	logic signed [39:0] lh_s3;
	logic [47:0] ll_s3;

	logic signed [56:0] x_full, visc_full;
	logic signed [63:0] lock_sum;
	logic signed [39:0] lock_raw, lim_x, lock_c;

	logic signed [56:0] x_s4;
	logic signed [44:0] visc_s4;
	logic signed [31:0] lock_s4;

	logic [56:0] mag_full;

	always_comb begin
		l_x = 25'(item.rear_left_speed);
		r_x = 25'(item.rear_right_speed);
		abs_l = l_x[24] ? -l_x : l_x;
		abs_r = r_x[24] ? -r_x : r_x;
		abs_sum = 26'(abs_l) + 26'(abs_r);
		fade = (abs_sum > 26'd4096) ? 13'd4096 : abs_sum[12:0];
	end

	always_comb begin
		x_full = $signed({1'b0, cfg.coulomb_stiffness}) * w_s3;
		visc_full = $signed({1'b0, cfg.viscous_coeff}) * w_s3;
		// Locking product rebuilt from its high and low partial products.
		lock_sum = $signed({lh_s3, 24'd0}) + $signed({16'd0, ll_s3});
		lock_raw = lock_sum[63:24];
		lim_x = $signed({9'd0, cfg.lock_limit});
		if (lock_raw > lim_x) begin
			lock_c = lim_x;
		end else if (lock_raw < -lim_x) begin
			lock_c = -lim_x;
		end else begin
			lock_c = lock_raw;
		end
		mag_full = x_s4[56] ? 57'(-x_s4) : 57'(x_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tq_s1 <= item.motor_torque;
			sum_s1 <= l_x + r_x;
			diff_s1 <= l_x - r_x;
			fade_s1 <= fade;

			tq_s2 <= tq_s1;
			sg_s2 <= 50'(sum_s1 * $signed({1'b0, cfg.axle_ratio}));
			pdf_s2 <= 39'(diff_s1 * $signed({1'b0, fade_s1}));

			tq_s3 <= tq_s2;
			w_s3 <= sg_s2[48:17];
			lh_s3 <= 40'($signed(pdf_s2[38:24]) * $signed({1'b0, cfg.lock_gain}));
			ll_s3 <= 48'(pdf_s2[23:0] * cfg.lock_gain);

			tq_s4 <= tq_s3;
			x_s4 <= x_full;
			visc_s4 <= visc_full[56:12];
			lock_s4 <= lock_c[31:0];

			front.tq <= tq_s4;
			front.visc <= visc_s4;
			front.lock <= lock_s4;
			front.mag <= mag_full[55:0];
			front.neg <= x_s4[56];
			front.near <= (mag_full <= 57'(1) << 28);
		end
	end

	assign out_valid = v_s[4];

endmodule
`default_nettype wire

[rtl/vdts_recip.sv]
// Pipelined restoring divider giving 2^56 / |x| for the far atan branch.
// DIV_STAGES register stages carry the front end terms alongside; uses vdts_pkg.
`default_nettype none
module vdts_recip (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vdts_pkg::front_t front_in,
	output logic             out_valid,
	output vdts_pkg::front_t front_out,
	output logic [vdts_pkg::DIV_BITS-1:0] quot
);
	import vdts_pkg::*;

	typedef struct packed {
		logic [56:0] rem;
		logic [DIV_BITS-1:0] q;
	} dstep_t;

	// The dividend 2^56 has no bits below 2^28 and the divisor exceeds 2^28,
	// so the division starts with a partial remainder of 2^28.
	localparam dstep_t DIV_INIT = '{rem: 57'(1) << 28, q: '0};

	function automatic dstep_t div_step(dstep_t cur, logic [55:0] d);
		dstep_t nxt;
		logic [56:0] sh;
		nxt = cur;
		for (int j = 0; j < DIV_PER_STAGE; j++) begin
			sh = {nxt.rem[55:0], 1'b0};
			if (sh >= {1'b0, d}) begin
				nxt.rem = sh - {1'b0, d};
				nxt.q = {nxt.q[DIV_BITS-2:0], 1'b1};
			end else begin
				nxt.rem = sh;
				nxt.q = {nxt.q[DIV_BITS-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	logic [DIV_STAGES-1:0] v_s;
	dstep_t st_s [DIV_STAGES];
	front_t side_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(DIV_INIT, front_in.mag);
			side_s[0] <= front_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				st_s[k] <= div_step(st_s[k-1], side_s[k-1].mag);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign front_out = side_s[DIV_STAGES-1];
	assign quot = st_s[DIV_STAGES-1].q;

endmodule
`default_nettype wire

[rtl/vdts_sign.sv]
// Smooth sign (2/pi)*atan(x) from an interpolated table held in a ROM.
// Two register stages (ROM read, interpolation); uses vdts_pkg.
`default_nettype none
module vdts_sign (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vdts_pkg::front_t front,
	input  logic [vdts_pkg::DIV_BITS-1:0] quot,
	output logic             out_valid,
	output vdts_pkg::tail_t  tail
);
	import vdts_pkg::*;

	localparam int POS_W = 29 + $clog2(ATAN_ENTRIES + 1);
	localparam int IDX_W = POS_W - 28;

	typedef logic [33:0] rom_word_t;
	typedef rom_word_t rom_arr_t [ATAN_ENTRIES];
	typedef longint angle_arr_t [20];

	// (2/pi)*atan(2^-k) in units of 2^-24.
	localparam angle_arr_t CORDIC_ANGLE = '{
		8388608, 4952084, 2616546, 1328199, 666677, 333664, 166872, 83441,
		41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20
	};

	function automatic logic [16:0] atan_point(int i);
		longint x, y, z, xs, ys, r;
		x = longint'(ATAN_ENTRIES) <<< 24;
		y = longint'(i) <<< 24;
		z = 0;
		for (int k = 0; k < 20; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + CORDIC_ANGLE[k];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - CORDIC_ANGLE[k];
			end
		end
		r = (z + 128) >>> 8;
		if (r < 0) begin
			r = 0;
		end
		if (r > 65536) begin
			r = 65536;
		end
		return r[16:0];
	endfunction

	// Each word holds a point and its right neighbor, so one read interpolates.
	function automatic rom_arr_t build_rom();
		rom_arr_t t;
		for (int i = 0; i < ATAN_ENTRIES; i++) begin
			t[i] = {atan_point(i + 1), atan_point(i)};
		end
		return t;
	endfunction

	localparam rom_arr_t ATAN_ROM = build_rom();
	localparam logic [16:0] ATAN_END = atan_point(ATAN_ENTRIES);

	logic [1:0] v_s;

	logic [28:0] t_arg;
	logic [POS_W-1:0] pos;
	logic [IDX_W-1:0] idx;
	logic at_end;
	logic [ATAN_AW-1:0] addr;

	rom_word_t pair_s1;
	logic at_end_s1, near_s1, neg_s1;
	logic [27:0] fr_s1;
	logic signed [31:0] tq_s1, lock_s1;
	logic signed [44:0] visc_s1;

	logic signed [17:0] pdiff;
	logic signed [46:0] prod;
	logic signed [19:0] interp, val;

	always_comb begin
		t_arg = front.near ? front.mag[28:0] : 29'(quot);
		pos = POS_W'(t_arg) * POS_W'(ATAN_ENTRIES);
		idx = pos[POS_W-1:28];
		at_end = (idx >= IDX_W'(ATAN_ENTRIES));
		addr = at_end ? '0 : idx[ATAN_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= ATAN_ROM[addr];
			at_end_s1 <= at_end;
			fr_s1 <= pos[27:0];
			near_s1 <= front.near;
			neg_s1 <= front.neg;
			tq_s1 <= front.tq;
			visc_s1 <= front.visc;
			lock_s1 <= front.lock;
		end
	end

	always_comb begin
		pdiff = $signed({1'b0, pair_s1[33:17]}) - $signed({1'b0, pair_s1[16:0]});
		prod = 47'(pdiff * $signed({1'b0, fr_s1}));
		interp = $signed({3'd0, pair_s1[16:0]}) + 20'(prod[46:28]);
		if (at_end_s1) begin
			interp = $signed({3'd0, ATAN_END});
		end
		// Beyond one the angle is the complement of atan(1/x).
		val = near_s1 ? interp : 20'sd65536 - interp;
		if (neg_s1) begin
			val = -val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail.tq <= tq_s1;
			tail.visc <= visc_s1;
			tail.lock <= lock_s1;
			tail.sgn <= val[17:0];
		end
	end

	assign out_valid = v_s[1];

endmodule
`default_nettype wire

[rtl/vdts_back.sv]
// Back end: Coulomb drag, shaft torque, efficiency, gear and the left/right split.
// Seven register stages, the last one is the output register; uses vdts_pkg.
`default_nettype none
module vdts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  vdts_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  vdts_pkg::tail_t tail,
	output logic            out_valid,
	output logic signed [31:0] left_torque,
	output logic signed [31:0] right_torque
);
	import vdts_pkg::*;

	function automatic logic signed [31:0] sat32(logic signed [55:0] v);
		if (v > 56'sh0000_0000_7fff_ffff) begin
			return 32'sh7fff_ffff;
		end else if (v < -56'sh0000_0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	logic [6:0] v_s;

	logic signed [50:0] cp_s1;
	logic signed [31:0] tq_s1, lock_s1, lock_s2, lock_s3, lock_s4, lock_s5, lock_s6;
	logic signed [44:0] visc_s1;
	logic signed [46:0] shaft_s2;
	logic signed [40:0] eh_s3;
	logic [40:0] el_s3;
	logic signed [47:0] a_s4;
	logic signed [48:0] gh_s5;
	logic [47:0] gl_s5;
	logic signed [54:0] half_s6;

	logic signed [34:0] coul;
	logic signed [64:0] esum;
	logic signed [72:0] gsum;

	always_comb begin
		coul = cp_s1[50:16];
		esum = $signed({eh_s3, 24'd0}) + $signed({24'd0, el_s3});
		gsum = $signed({gh_s5, 24'd0}) + $signed({25'd0, gl_s5});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s1 <= 51'($signed({1'b0, cfg.coulomb_torque}) * tail.sgn);
			tq_s1 <= tail.tq;
			visc_s1 <= tail.visc;
			lock_s1 <= tail.lock;

			shaft_s2 <= 47'(tq_s1) - 47'(visc_s1) - 47'(coul);
			lock_s2 <= lock_s1;

			// Efficiency product split at bit 24 to keep each multiplier narrow.
			eh_s3 <= 41'($signed(shaft_s2[46:24]) * $signed({1'b0, cfg.drive_efficiency}));
			el_s3 <= 41'(shaft_s2[23:0] * cfg.drive_efficiency);
			lock_s3 <= lock_s2;

			a_s4 <= esum[63:16];
			lock_s4 <= lock_s3;

			gh_s5 <= 49'($signed(a_s4[47:24]) * $signed({1'b0, cfg.axle_ratio}));
			gl_s5 <= 48'(a_s4[23:0] * cfg.axle_ratio);
			lock_s5 <= lock_s4;

			half_s6 <= gsum[71:17];
			lock_s6 <= lock_s5;

			left_torque <= sat32(56'(half_s6) - 56'(lock_s6));
			right_torque <= sat32(56'(half_s6) + 56'(lock_s6));
		end
	end

	assign out_valid = v_s[6];

endmodule
`default_nettype wire

[rtl/viscous_differential_torque_split_top.sv]
// Top level of the viscous differential torque split: configuration registers
// and the pipeline. Depends on vdts_pkg, the channel interfaces and the submodules.
`default_nettype none
// One request enters per cycle while the output is not held. Its two rear torques
// pass five front end stages, fourteen reciprocal divider stages (two quotient
// bits each), two stages for the atan ROM read and interpolation and seven back
// end stages ending in the output register. The whole pipeline advances together;
// when the output is held, every stage holds and the input is not ready. The user
// must write configuration registers through cfg only while the block is idle; the block does not enforce it.
module viscous_differential_torque_split_top (
	input  logic       clk,
	input  logic       arst_n,
	vdts_in_if.sink    in_ch,
	vdts_out_if.source out_ch,
	vdts_cfg_if.sink   cfg
);
	import vdts_pkg::*;

	cfg_t cfg_q;
	logic en;
	item_t item;

	logic f_valid, d_valid, s_valid, b_valid;
	front_t f_data, d_data;
	logic [DIV_BITS-1:0] quot;
	tail_t s_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axle_ratio <= 24'd262144;
			cfg_q.drive_efficiency <= 17'd62259;
			cfg_q.viscous_coeff <= '0;
			cfg_q.coulomb_torque <= '0;
			cfg_q.coulomb_stiffness <= 24'd655360;
			cfg_q.lock_gain <= '0;
			cfg_q.lock_limit <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_AXLE_RATIO:        cfg_q.axle_ratio <= cfg.wdata[23:0];
				REG_DRIVE_EFFICIENCY:  cfg_q.drive_efficiency <= cfg.wdata[16:0];
				REG_VISCOUS_COEFF:     cfg_q.viscous_coeff <= cfg.wdata[23:0];
				REG_COULOMB_TORQUE:    cfg_q.coulomb_torque <= cfg.wdata;
				REG_COULOMB_STIFFNESS: cfg_q.coulomb_stiffness <= cfg.wdata[23:0];
				REG_LOCK_GAIN:         cfg_q.lock_gain <= cfg.wdata[23:0];
				REG_LOCK_LIMIT:        cfg_q.lock_limit <= cfg.wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	assign en = !b_valid || out_ch.ready;
	assign in_ch.ready = en;

	assign item.motor_torque = in_ch.motor_torque;
	assign item.rear_left_speed = in_ch.rear_left_speed;
	assign item.rear_right_speed = in_ch.rear_right_speed;

	vdts_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(in_ch.valid), .item(item),
		.out_valid(f_valid), .front(f_data)
	);

	vdts_recip u_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .front_in(f_data),
		.out_valid(d_valid), .front_out(d_data), .quot(quot)
	);

	vdts_sign u_sign (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d_valid), .front(d_data), .quot(quot),
		.out_valid(s_valid), .tail(s_data)
	);

	vdts_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(s_valid), .tail(s_data),
		.out_valid(b_valid),
		.left_torque(out_ch.rear_left_torque),
		.right_torque(out_ch.rear_right_torque)
	);

	assign out_ch.valid = b_valid;

endmodule
`default_nettype wire

[rtl/vdts_checker.sv]
// Port level checks for the torque split pipeline, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module vdts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_left,
	input logic [31:0] out_right
);

	// A held result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
		else $error("result changed while stalled");

	// The pipeline only stalls requests when the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request stalled while the output drains");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request stalled with an empty output register");

endmodule

bind viscous_differential_torque_split_top vdts_checker u_vdts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_left(out_ch.rear_left_torque),
	.out_right(out_ch.rear_right_torque)
);
`default_nettype wire
